// ===== src/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg - shared types and constants for the frustum cull test unit
// Plane register layout, test kinds and fixed-point alignment constants.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Six frustum planes: near, far, left, right, top, bottom
    localparam int NUM_PLANES      = 6;
    localparam int CFG_INDEX_W     = $clog2(NUM_PLANES);
    localparam int CFG_DATA_W      = 64;
    localparam int COEF_W          = 16;
    localparam int COORD_WIDTH_DEF = 16;

    // d and radius are Q.4; products a*x are Q.18, so align by 14 bits
    localparam int FRAC_ALIGN      = 14;

    // Register indices
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_NEAR   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_BOTTOM = CFG_INDEX_W'(NUM_PLANES - 1);

    // One plane as written to its register: a in the low 16 bits, d on top
    typedef struct packed {
        logic signed [COEF_W-1:0] d;    // Q12.4
        logic signed [COEF_W-1:0] c;    // Q1.14
        logic signed [COEF_W-1:0] b;    // Q1.14
        logic signed [COEF_W-1:0] a;    // Q1.14
    } plane_t;

    // Kind of primitive under test
    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_CUBE   = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } op_t;

endpackage

// ===== src/frc_plane_regs.sv =====
// ----------------------------------------------------------------------------
// frc_plane_regs - frustum plane register file
// Holds the six packed plane registers; writes past the last index are dropped.
// ----------------------------------------------------------------------------
module frc_plane_regs import frc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output plane_t                 planes [NUM_PLANES]
);

    plane_t planes_reg [NUM_PLANES];
    logic   index_ok;

    // Only the near..bottom range maps onto a register
    assign index_ok = (cfg_index >= REG_PLANE_NEAR) && (cfg_index <= REG_PLANE_BOTTOM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                planes_reg[i] <= '0;
            end
        end else if (cfg_wr_en && index_ok) begin
            planes_reg[cfg_index] <= plane_t'(cfg_data);
        end
    end

    assign planes = planes_reg;

endmodule

// ===== src/frc_plane_lane.sv =====
// ----------------------------------------------------------------------------
// frc_plane_lane - distance test of one primitive against one plane
// Picks the corner furthest along the plane normal and checks its distance.
// ----------------------------------------------------------------------------
module frc_plane_lane import frc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  plane_t                       plane,
    input  logic signed [COORD_WIDTH:0]  x_lo,
    input  logic signed [COORD_WIDTH:0]  x_hi,
    input  logic signed [COORD_WIDTH:0]  y_lo,
    input  logic signed [COORD_WIDTH:0]  y_hi,
    input  logic signed [COORD_WIDTH:0]  z_lo,
    input  logic signed [COORD_WIDTH:0]  z_hi,
    input  logic [COORD_WIDTH-2:0]       radius,
    output logic                         keep
);

    // Product of a 16-bit coefficient and a corner coordinate
    localparam int PROD_W = COEF_W + COORD_WIDTH + 1;
    // d plus radius, one bit over the wider of the two as signed values
    localparam int DR_W   = ((COORD_WIDTH > COEF_W) ? COORD_WIDTH : COEF_W) + 1;
    // Sum of three products and the aligned offset never overflows this
    localparam int ACC_W  = COORD_WIDTH + 19;

    logic signed [COORD_WIDTH:0] x_sel, y_sel, z_sel;
    logic signed [PROD_W-1:0]    prod_x, prod_y, prod_z;
    logic signed [DR_W-1:0]      offset;
    logic signed [ACC_W-1:0]     plane_dist;

    // A negative coefficient is maximised by the low corner on that axis
    assign x_sel = plane.a[COEF_W-1] ? x_lo : x_hi;
    assign y_sel = plane.b[COEF_W-1] ? y_lo : y_hi;
    assign z_sel = plane.c[COEF_W-1] ? z_lo : z_hi;

    assign prod_x = PROD_W'(plane.a) * PROD_W'(x_sel);
    assign prod_y = PROD_W'(plane.b) * PROD_W'(y_sel);
    assign prod_z = PROD_W'(plane.c) * PROD_W'(z_sel);

    // Sphere radius folds into the plane offset; zero in the other modes
    assign offset = DR_W'(plane.d) + DR_W'(signed'({1'b0, radius}));

    assign plane_dist = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z)
                      + (ACC_W'(offset) <<< FRAC_ALIGN);

    assign keep = ~plane_dist[ACC_W-1];

endmodule

// ===== src/frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_test_unit - six-plane view frustum culling test
// Tests a point, cube, sphere or box against six configured planes.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------------
//   s_       | in        | s_valid / s_ready | operation, center_*, size_*
//   m_       | out       | m_valid / m_ready | visible
//   cfg_     | in        | cfg_wr_en         | cfg_index, cfg_data
//
// One item per cycle sustained while m_ready keeps the result register moving;
// an accepted item lands in the input register and then moves to the result register, which drives m_valid.
// The six plane lanes work in parallel between those two registers.
// Reset clears the planes to zero (everything visible) and empties the pipe.
// A stalled result holds the result register; one more item still enters the
// input register, after which s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module frustum_cull_test_unit import frc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Plane configuration
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // Query input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic signed [COORD_WIDTH-1:0] s_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_center_y,
    input  logic signed [COORD_WIDTH-1:0] s_center_z,
    input  logic [COORD_WIDTH-2:0]        s_size_x,
    input  logic [COORD_WIDTH-2:0]        s_size_y,
    input  logic [COORD_WIDTH-2:0]        s_size_z,
    // Result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_visible
);

    plane_t planes [NUM_PLANES];

    logic                          in_valid_reg;
    op_t                           op_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg, cz_reg;
    logic [COORD_WIDTH-2:0]        sx_reg, sy_reg, sz_reg;

    logic                          out_valid_reg;
    logic                          visible_reg;
    logic                          visible_next;

    logic                          advance;

    logic [COORD_WIDTH-2:0]        hx, hy, hz, radius;
    logic signed [COORD_WIDTH:0]   x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic [NUM_PLANES-1:0]         keep;

    // Plane registers
    frc_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // Pipe control: result register moves when empty or taken
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_t'(s_operation);
            cx_reg <= s_center_x;
            cy_reg <= s_center_y;
            cz_reg <= s_center_z;
            sx_reg <= s_size_x;
            sy_reg <= s_size_y;
            sz_reg <= s_size_z;
        end
    end

    // Half sizes and radius per test kind
    always_comb begin
        hx     = '0;
        hy     = '0;
        hz     = '0;
        radius = '0;
        unique case (op_reg)
            OP_POINT: begin
            end
            OP_CUBE: begin
                hx = sx_reg;
                hy = sx_reg;
                hz = sx_reg;
            end
            OP_SPHERE: begin
                radius = sx_reg;
            end
            OP_BOX: begin
                hx = sx_reg;
                hy = sy_reg;
                hz = sz_reg;
            end
            default: begin
            end
        endcase
    end

    // Corner coordinates, one bit wider than the centre
    assign x_lo = (COORD_WIDTH+1)'(cx_reg) - (COORD_WIDTH+1)'(signed'({1'b0, hx}));
    assign x_hi = (COORD_WIDTH+1)'(cx_reg) + (COORD_WIDTH+1)'(signed'({1'b0, hx}));
    assign y_lo = (COORD_WIDTH+1)'(cy_reg) - (COORD_WIDTH+1)'(signed'({1'b0, hy}));
    assign y_hi = (COORD_WIDTH+1)'(cy_reg) + (COORD_WIDTH+1)'(signed'({1'b0, hy}));
    assign z_lo = (COORD_WIDTH+1)'(cz_reg) - (COORD_WIDTH+1)'(signed'({1'b0, hz}));
    assign z_hi = (COORD_WIDTH+1)'(cz_reg) + (COORD_WIDTH+1)'(signed'({1'b0, hz}));

    // One lane per plane
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        frc_plane_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .plane  (planes[p]),
            .x_lo   (x_lo),
            .x_hi   (x_hi),
            .y_lo   (y_lo),
            .y_hi   (y_hi),
            .z_lo   (z_lo),
            .z_hi   (z_hi),
            .radius (radius),
            .keep   (keep[p])
        );
    end

    // Visible only when no plane rejects
    assign visible_next = &keep;

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            visible_reg <= visible_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_visible = visible_reg;

    // Checks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are stalled");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item missing from input register");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared with no item behind it");

endmodule

// ===== verif/tb_frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// tb_frustum_cull_test_unit - self-checking bench for the frustum cull unit
// Drives culling queries through the valid/ready input, predicts visibility
// from its own copy of the six plane registers, and compares each result
// item in order. A directed opening covers field extremes, every primitive
// kind and the touching cases; random phases follow with fresh planes and
// varied idling on both sides, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_frustum_cull_test_unit;
    import frc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int PIPE_DRAIN   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int Q14_ONE      = 1 << FRAC_ALIGN;

    // Plane registers not named in the package
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FAR   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_LEFT  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_RIGHT = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_TOP   = CFG_INDEX_W'(4);
    // Indexes past the last plane; writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO    = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI    = CFG_INDEX_W'(7);

    // Idling per phase mode, percent of cycles
    localparam int SEND_IDLE[4] = '{0, 78, 0, 22};
    localparam int RECV_STALL[4] = '{0, 0, 78, 22};

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [COORD_W-2:0]        sx;
        logic [COORD_W-2:0]        sy;
        logic [COORD_W-2:0]        sz;
    } query_t;

    // ------------------------------------------------------------------------
    // Visibility scoreboard: shadow planes, predicted results in order
    // ------------------------------------------------------------------------
    class visibility_board;
        plane_t planes[NUM_PLANES];
        bit     pending_vis[$];
        int     errors;

        function new();
            foreach (planes[i]) planes[i] = '0;
            errors = 0;
        endfunction

        function void set_plane(int idx, logic [CFG_DATA_W-1:0] data);
            if (idx < NUM_PLANES) planes[idx] = plane_t'(data);
        endfunction

        // Exact signed distance, 18 fractional bits
        function longint distance(plane_t p, longint x, longint y, longint z);
            return longint'($signed(p.a)) * x + longint'($signed(p.b)) * y
                 + longint'($signed(p.c)) * z
                 + longint'($signed(p.d)) * longint'(Q14_ONE);
        endfunction

        // A plane rejects only when all eight corners lie behind it
        function bit box_clear(longint cx, longint cy, longint cz,
                               longint hx, longint hy, longint hz);
            bit     kept;
            longint x, y, z;
            for (int p = 0; p < NUM_PLANES; p++) begin
                kept = 1'b0;
                for (int k = 0; k < 8; k++) begin
                    x = ((k & 1) != 0) ? cx + hx : cx - hx;
                    y = ((k & 2) != 0) ? cy + hy : cy - hy;
                    z = ((k & 4) != 0) ? cz + hz : cz - hz;
                    if (distance(planes[p], x, y, z) >= 0) kept = 1'b1;
                end
                if (!kept) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit predict_visible(query_t q);
            longint cx, cy, cz, sx, sy, sz;
            bit     vis;
            cx  = longint'($signed(q.cx));
            cy  = longint'($signed(q.cy));
            cz  = longint'($signed(q.cz));
            sx  = longint'(q.sx);
            sy  = longint'(q.sy);
            sz  = longint'(q.sz);
            vis = 1'b1;
            case (q.op)
                OP_POINT: begin
                    foreach (planes[p])
                        if (distance(planes[p], cx, cy, cz) < 0) vis = 1'b0;
                end
                OP_SPHERE: begin
                    foreach (planes[p])
                        if (distance(planes[p], cx, cy, cz) < -(sx * Q14_ONE))
                            vis = 1'b0;
                end
                OP_CUBE: vis = box_clear(cx, cy, cz, sx, sx, sx);
                default: vis = box_clear(cx, cy, cz, sx, sy, sz);
            endcase
            return vis;
        endfunction

        function void note_query(query_t q);
            pending_vis.push_back(predict_visible(q));
        endfunction

        function void check_result(bit vis);
            bit want;
            if (pending_vis.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual visible=%0b",
                         $time, vis);
            end else begin
                want = pending_vis.pop_front();
                if (vis !== want) begin
                    errors++;
                    $display("%0t: visible mismatch, expected %0b, actual %0b",
                             $time, want, vis);
                end
            end
        endfunction

        function int pending();
            return pending_vis.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        cfg_data    = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_operation = '0;
    logic signed [COORD_W-1:0]    s_center_x  = '0;
    logic signed [COORD_W-1:0]    s_center_y  = '0;
    logic signed [COORD_W-1:0]    s_center_z  = '0;
    logic [COORD_W-2:0]           s_size_x    = '0;
    logic [COORD_W-2:0]           s_size_y    = '0;
    logic [COORD_W-2:0]           s_size_z    = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic                         m_visible;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;

    // Current frustum bounds, Q12.4; shaped queries aim around them
    int lo_x = -1600, hi_x = 1600, lo_y = -1600, hi_y = 1600, lo_z = 16, hi_z = 8000;

    visibility_board sb = new();

    frustum_cull_test_unit #(
        .COORD_WIDTH (COORD_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_center_x  (s_center_x),
        .s_center_y  (s_center_y),
        .s_center_z  (s_center_z),
        .s_size_x    (s_size_x),
        .s_size_y    (s_size_y),
        .s_size_z    (s_size_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_visible   (m_visible)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        #1ms;
        $display("** frustum_cull_test_unit: FAILED **");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != holds_requested) begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor both handshakes
    always @(posedge aclk) begin
        query_t q;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                q.op = op_t'(s_operation);
                q.cx = s_center_x;
                q.cy = s_center_y;
                q.cz = s_center_z;
                q.sx = s_size_x;
                q.sy = s_size_y;
                q.sz = s_size_z;
                sb.note_query(q);
            end
            if (m_valid && m_ready) sb.check_result(m_visible);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return COORD_W'(v);
    endfunction

    function automatic query_t mkq(op_t op, int cx, int cy, int cz,
                                   int sx, int sy, int sz);
        query_t q;
        q.op = op;
        q.cx = to_coord(cx);
        q.cy = to_coord(cy);
        q.cz = to_coord(cz);
        q.sx = (COORD_W-1)'(sx);
        q.sy = (COORD_W-1)'(sy);
        q.sz = (COORD_W-1)'(sz);
        return q;
    endfunction

    // Mostly modest sizes, now and then the full range
    function automatic logic [COORD_W-2:0] pick_size();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return (COORD_W-1)'($urandom_range(800));
        if (sel < 9) return (COORD_W-1)'($urandom_range(4000));
        return (COORD_W-1)'($urandom);
    endfunction

    // Queries around the frustum, with some raw noise
    function automatic query_t shaped_query();
        query_t q;
        q.op = op_t'($urandom_range(3));
        if ($urandom_range(99) < 15) begin
            q.cx = COORD_W'($urandom);
            q.cy = COORD_W'($urandom);
            q.cz = COORD_W'($urandom);
            q.sx = (COORD_W-1)'($urandom);
            q.sy = (COORD_W-1)'($urandom);
            q.sz = (COORD_W-1)'($urandom);
        end else begin
            q.cx = to_coord(rand_between(lo_x - 1500, hi_x + 1500));
            q.cy = to_coord(rand_between(lo_y - 1500, hi_y + 1500));
            q.cz = to_coord(rand_between(lo_z - 1500, hi_z + 1500));
            q.sx = pick_size();
            q.sy = pick_size();
            q.sz = pick_size();
        end
        return q;
    endfunction

    // Plane facing along one axis through the given bound; optional tilt
    function automatic logic [CFG_DATA_W-1:0] axis_plane(int axis, int dir,
                                                         int bound, bit tilted);
        int     n[3];
        int     mag;
        plane_t p;
        mag = tilted ? Q14_ONE + rand_between(-3000, 3000) : Q14_ONE;
        for (int i = 0; i < 3; i++)
            n[i] = (i == axis) ? dir * mag : (tilted ? rand_between(-2000, 2000) : 0);
        p.a = COEF_W'(n[0]);
        p.b = COEF_W'(n[1]);
        p.c = COEF_W'(n[2]);
        p.d = COEF_W'((-(n[axis] * bound)) / Q14_ONE);
        return p;
    endfunction

    // Register write; the caller lowers the enable after the last one
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.set_plane(int'(idx), data);
    endtask

    task automatic program_frustum(bit tilted);
        write_reg(REG_PLANE_NEAR,   axis_plane(2,  1, lo_z, tilted));
        write_reg(REG_PLANE_FAR,    axis_plane(2, -1, hi_z, tilted));
        write_reg(REG_PLANE_LEFT,   axis_plane(0,  1, lo_x, tilted));
        write_reg(REG_PLANE_RIGHT,  axis_plane(0, -1, hi_x, tilted));
        write_reg(REG_PLANE_TOP,    axis_plane(1, -1, hi_y, tilted));
        write_reg(REG_PLANE_BOTTOM, axis_plane(1,  1, lo_y, tilted));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_all(logic [CFG_DATA_W-1:0] data);
        for (int i = REG_PLANE_NEAR; i <= REG_PLANE_BOTTOM; i++)
            write_reg(CFG_INDEX_W'(i), data);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one item, holding it until accepted
    task automatic send_query(query_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= q.op;
        s_center_x  <= q.cx;
        s_center_y  <= q.cy;
        s_center_z  <= q.cz;
        s_size_x    <= q.sx;
        s_size_y    <= q.sy;
        s_size_z    <= q.sz;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and let every outstanding result come back
    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int mode;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset planes: everything visible, field extremes
        send_query(mkq(OP_POINT, -32768, 32767, -32768, 0, 0, 0));
        send_query(mkq(OP_CUBE, 32767, -32768, 32767, 32767, 0, 0));
        send_query(mkq(OP_SPHERE, 0, 0, 0, 0, 32767, 32767));
        send_query(mkq(OP_BOX, -32768, -32768, -32768, 32767, 0, 32767));
        quiesce();

        // Writes past the last plane are dropped
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, 64'h8000_8000_8000_8000);
        cfg_wr_en <= 1'b0;
        send_query(mkq(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
        quiesce();

        // Extreme coefficients
        program_all(64'h8000_8000_8000_8000);
        send_query(mkq(OP_POINT, -32768, -32768, -32768, 0, 0, 0));
        send_query(mkq(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
        quiesce();
        program_all(64'h7FFF_7FFF_7FFF_7FFF);
        send_query(mkq(OP_POINT, 32767, 32767, 32767, 0, 0, 0));
        send_query(mkq(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        quiesce();

        // Axis-aligned frustum: touching and just-missing cases
        program_frustum(1'b0);
        send_query(mkq(OP_POINT, 0, 0, 100, 32767, 32767, 32767));
        send_query(mkq(OP_POINT, -1600, 0, 100, 0, 0, 0));      // on the plane
        send_query(mkq(OP_POINT, -1601, 0, 100, 0, 0, 0));      // one step out
        send_query(mkq(OP_SPHERE, -1700, 0, 100, 100, 0, 0));   // touching
        send_query(mkq(OP_SPHERE, -1700, 0, 100, 99, 32767, 32767));
        send_query(mkq(OP_CUBE, -1700, 0, 100, 100, 0, 0));     // corner on plane
        send_query(mkq(OP_CUBE, -1700, 0, 100, 99, 32767, 32767));
        send_query(mkq(OP_BOX, 0, 1700, 100, 0, 100, 0));
        send_query(mkq(OP_BOX, 0, 1700, 100, 5000, 99, 5000));
        send_query(mkq(OP_BOX, 0, 0, -32768, 32767, 32767, 32767));
        send_query(mkq(OP_SPHERE, 32767, 32767, 32767, 32767, 0, 0));
        send_query(mkq(OP_CUBE, -32768, -32768, -32768, 32767, 0, 0));
        quiesce();

        // Random phases: new planes, a different idling mix each time
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            mode           = ph % 4;
            send_idle_pct  = SEND_IDLE[mode];
            recv_stall_pct = RECV_STALL[mode];
            lo_x = -rand_between(100, 12000);
            hi_x = rand_between(100, 12000);
            lo_y = -rand_between(100, 12000);
            hi_y = rand_between(100, 12000);
            lo_z = rand_between(0, 2000);
            hi_z = lo_z + rand_between(500, 24000);
            if ($urandom_range(3) == 0)
                for (int i = REG_PLANE_NEAR; i <= REG_PLANE_BOTTOM; i++)
                    write_reg(CFG_INDEX_W'(i), {$urandom, $urandom});
            else
                program_frustum(1'($urandom_range(1)));
            cfg_wr_en <= 1'b0;
            // Long hold-off so the pipe fills and back-pressures the sender
            if (mode == 0) holds_requested <= holds_requested + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_query(shaped_query());
            quiesce();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** frustum_cull_test_unit: PASSED **");
        else
            $display("** frustum_cull_test_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/frc_pkg.sv
src/frc_plane_regs.sv
src/frc_plane_lane.sv
src/frustum_cull_test_unit.sv
verif/tb_frustum_cull_test_unit.sv
